// ----- rtl/pec_pkg.sv -----
`default_nettype none

package pec_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_START_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_START_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_END_X   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_END_Y   = 2'd3;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } pec_op_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    req;
    pec_op_t op;
  } pec_ctl_t;

  // unit status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pec_rsp_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_ABSN,
    U_ABSD,
    U_DIV,
    U_SAT,
    U_DONE
  } pec_ustate_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS1,
    ST_POS2,
    ST_EDGE,
    ST_DIFF,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV,
    ST_EMIT_X,
    ST_EMIT_K,
    ST_NEXT,
    ST_EMPTY
  } pec_state_t;

  // point whose side value the sequencer is forming
  typedef enum logic [1:0] {
    PT_CUR,
    PT_PREV,
    PT_FIRST
  } pec_pt_t;

endpackage

`default_nettype wire

// ----- rtl/pec_unit.sv -----
`default_nettype none

// Shared radix-2 unit: signed shift-add multiply (W+1 by 2W+3 bits) and
// signed restoring divide with truncation and saturation to W bits.
module pec_unit #(
  parameter int W = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pec_pkg::pec_ctl_t    ctl,
  input  wire logic [3*W+3:0]       opa,
  input  wire logic [2*W+2:0]       opb,
  output      pec_pkg::pec_rsp_t    rsp,
  output      logic [3*W+3:0]       res
);

  localparam int AW  = W + 1;
  localparam int BW  = 2 * W + 3;
  localparam int PW  = AW + BW;
  localparam int NMW = 3 * W + 2;
  localparam int DMW = 2 * W + 2;
  localparam int QW  = W + 1;
  localparam int CW  = $clog2(W + 1);

  pec_pkg::pec_ustate_t ust_r, ust_nxt;

  logic [PW:0]    acc_r, acc_nxt;
  logic [BW-1:0]  b_r, b_nxt;
  logic [PW-1:0]  num_r, num_nxt;
  logic [BW-1:0]  den_r, den_nxt;
  logic           negq_r, negq_nxt;
  logic [DMW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  res_r, res_nxt;

  logic           cnt_last;
  logic [BW:0]    p_cur, b_ext, addend, p_sum, p_new;
  logic           sub_step;
  logic [PW:0]    acc_shift;
  logic [PW-1:0]  neg_src, abs_val;
  logic [DMW:0]   rem_sh;
  logic [DMW+1:0] trial;
  logic           borrow;
  logic [QW-1:0]  q_lim, q_neg;
  logic [W-1:0]   sat_val;

  assign cnt_last = (cnt_r == CW'(W));

  // multiply step; the last (sign) bit of the multiplier subtracts
  assign sub_step  = cnt_last;
  assign p_cur     = acc_r[PW:AW];
  assign b_ext     = {b_r[BW-1], b_r};
  assign addend    = sub_step ? ~b_ext : b_ext;
  assign p_sum     = p_cur + addend + {{BW{1'b0}}, sub_step};
  assign p_new     = acc_r[0] ? p_sum : p_cur;
  assign acc_shift = {p_new[BW], p_new, acc_r[AW-1:1]};

  // one negator for both operand magnitudes
  assign neg_src = (ust_r == pec_pkg::U_ABSN) ? num_r : {{(PW-BW){den_r[BW-1]}}, den_r};
  assign abs_val = neg_src[PW-1] ? (~neg_src + {{(PW-1){1'b0}}, 1'b1}) : neg_src;

  // restoring divide step
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r[DMW-1:0]};
  assign borrow = trial[DMW+1];

  // saturation to the signed W-bit range
  assign q_lim = {2'b01, {(W-1){1'b0}}};
  assign q_neg = ~quo_r + {{(QW-1){1'b0}}, 1'b1};

  always_comb begin
    if (negq_r) begin
      sat_val = (quo_r > q_lim) ? {1'b1, {(W-1){1'b0}}} : q_neg[W-1:0];
    end else begin
      sat_val = (quo_r > q_lim - {{(QW-1){1'b0}}, 1'b1}) ? {1'b0, {(W-1){1'b1}}}
                                                        : quo_r[W-1:0];
    end
  end

  always_comb begin
    ust_nxt = ust_r;
    case (ust_r)
      pec_pkg::U_IDLE: begin
        if (ctl.req) begin
          ust_nxt = (ctl.op == pec_pkg::OP_MUL) ? pec_pkg::U_MUL : pec_pkg::U_ABSN;
        end
      end
      pec_pkg::U_MUL: begin
        if (cnt_last) begin
          ust_nxt = pec_pkg::U_DONE;
        end
      end
      pec_pkg::U_ABSN: ust_nxt = pec_pkg::U_ABSD;
      pec_pkg::U_ABSD: ust_nxt = pec_pkg::U_DIV;
      pec_pkg::U_DIV: begin
        if (cnt_last) begin
          ust_nxt = pec_pkg::U_SAT;
        end
      end
      pec_pkg::U_SAT:  ust_nxt = pec_pkg::U_DONE;
      pec_pkg::U_DONE: ust_nxt = pec_pkg::U_IDLE;
      default:         ust_nxt = pec_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    negq_nxt = negq_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    case (ust_r)
      pec_pkg::U_IDLE: begin
        if (ctl.req) begin
          cnt_nxt = '0;
          if (ctl.op == pec_pkg::OP_MUL) begin
            acc_nxt = {{(BW+1){1'b0}}, opa[AW-1:0]};
            b_nxt   = opb;
          end else begin
            num_nxt  = opa;
            den_nxt  = opb;
            negq_nxt = opa[PW-1] ^ opb[BW-1];
          end
        end
      end
      pec_pkg::U_MUL: begin
        acc_nxt = acc_shift;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_last) begin
          res_nxt = acc_shift[PW-1:0];
        end
      end
      pec_pkg::U_ABSN: begin
        num_nxt = abs_val;
      end
      pec_pkg::U_ABSD: begin
        den_nxt = abs_val[BW-1:0];
        // quotient fits QW bits, so the top numerator bits are below the divisor
        rem_nxt = {1'b0, num_r[NMW-1:QW]};
        quo_nxt = num_r[QW-1:0];
        cnt_nxt = '0;
      end
      pec_pkg::U_DIV: begin
        rem_nxt = borrow ? rem_sh[DMW-1:0] : trial[DMW-1:0];
        quo_nxt = {quo_r[QW-2:0], ~borrow};
        cnt_nxt = cnt_r + CW'(1);
      end
      pec_pkg::U_SAT: begin
        res_nxt = {{(PW-W){sat_val[W-1]}}, sat_val};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r <= pec_pkg::U_IDLE;
    end else begin
      ust_r <= ust_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    b_r    <= b_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    negq_r <= negq_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.busy = (ust_r != pec_pkg::U_IDLE);
  assign rsp.done = (ust_r == pec_pkg::U_DONE);
  assign res      = res_r;

endmodule

`default_nettype wire

// ----- rtl/polygon_edge_clip.sv -----
`default_nettype none

// Channel  Dir  Signals                                         Beat
// in_      in   in_valid/in_ready, in_vertex_x/y, in_end_of_... one polygon vertex
// out_     out  out_valid/out_ready, out_x/y, out_present/last  one clipped vertex
// cfg_     in   cfg_wr_en, cfg_index, cfg_wdata                 one line register
//
// Work: each vertex takes one side value (a cross product) as two multiplies on
//   the shared radix-2 unit (pec_unit); a crossing edge adds two multiplies and a
//   divide per axis; a mid-polygon line write redoes the previous and first side values.
// Reset: synchronous, active low; clears sequencer, polygon tracking, line regs.
// Stalls: in_ready only in idle; a held output beat parks the sequencer in its
//   emit state until the output register frees.
module polygon_edge_clip #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // vertex input
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       in_vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0]       in_vertex_y,
  input  wire logic                                in_end_of_polygon,
  // clipped vertex output
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [COORD_WIDTH-1:0]       out_x,
  output      logic signed [COORD_WIDTH-1:0]       out_y,
  output      logic                                out_present,
  output      logic                                out_last,
  // clip line registers
  input  wire logic                                cfg_wr_en,
  input  wire logic [pec_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [COORD_WIDTH-1:0]              cfg_wdata
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = W + 1;          // coordinate differences
  localparam int SW = 2 * W + 2;      // side value (cross product)
  localparam int BW = 2 * W + 3;      // divisor D = pos(I) - pos(K)
  localparam int PW = 3 * W + 4;      // products and the crossing numerator

  // ---------------------------------------------------------------------------
  // Clip line registers
  // ---------------------------------------------------------------------------
  logic [W-1:0] sx_r, sy_r, ex_r, ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pec_pkg::REG_LINE_START_X: sx_r <= cfg_wdata;
        pec_pkg::REG_LINE_START_Y: sy_r <= cfg_wdata;
        pec_pkg::REG_LINE_END_X:   ex_r <= cfg_wdata;
        pec_pkg::REG_LINE_END_Y:   ey_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // line direction, W+1 bits so it never wraps
  logic [AW-1:0] ldx, ldy;
  assign ldx = {ex_r[W-1], ex_r} - {sx_r[W-1], sx_r};
  assign ldy = {ey_r[W-1], ey_r} - {sy_r[W-1], sy_r};

  // ---------------------------------------------------------------------------
  // Sequencer and polygon state
  // ---------------------------------------------------------------------------
  pec_pkg::pec_state_t state_r, state_nxt;

  logic [W-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [W-1:0]  first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [W-1:0]  prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [SW-1:0] pos_cur_r, pos_cur_nxt, pos_prev_r, pos_prev_nxt;
  logic [SW-1:0] pos_first_r, pos_first_nxt, m1_r, m1_nxt;
  logic [BW-1:0] d_r, d_nxt;
  logic [PW-1:0] t_r, t_nxt;
  logic [W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic          last_r, last_nxt;
  logic          mid_r, mid_nxt;
  logic          phase_r, phase_nxt;      // 0: edge prev->cur, 1: closing edge cur->first
  logic          axis_r, axis_nxt;        // 0: x, 1: y
  logic          emitted_r, emitted_nxt;
  pec_pkg::pec_pt_t pt_r, pt_nxt;         // point under the side-value multiplies
  logic          dirty_r, dirty_nxt;      // line written since side values were cached

  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic          out_present_r, out_present_nxt;
  logic          out_last_r, out_last_nxt;

  // shared unit
  pec_pkg::pec_ctl_t u_ctl;
  pec_pkg::pec_rsp_t u_rsp;
  logic [PW-1:0]     u_opa, u_res;
  logic [BW-1:0]     u_opb;
  logic [AW-1:0]     a_in;

  // edge under work
  logic [W-1:0]  ix, iy, kx, ky, i_c, k_c;
  logic [SW-1:0] ip, kp;
  logic          iin, kin, edge_on, close_emits, more_after, slot_free;
  logic [SW-1:0] pos_new;
  logic [W-1:0]  px, py;

  assign ix = phase_r ? cur_x_r     : prev_x_r;
  assign iy = phase_r ? cur_y_r     : prev_y_r;
  assign kx = phase_r ? first_x_r   : cur_x_r;
  assign ky = phase_r ? first_y_r   : cur_y_r;
  assign ip = phase_r ? pos_cur_r   : pos_prev_r;
  assign kp = phase_r ? pos_first_r : pos_cur_r;

  assign i_c = axis_r ? iy : ix;
  assign k_c = axis_r ? ky : kx;

  // negative side value means inside; zero is outside
  assign iin = ip[SW-1];
  assign kin = kp[SW-1];

  // open edge needs a previous vertex; closing edge only on the last vertex
  assign edge_on     = phase_r ? last_r : mid_r;
  // the closing edge emits something when either of its ends is inside
  assign close_emits = pos_cur_r[SW-1] | pos_first_r[SW-1];
  // more beats of this polygon still to come after the current edge
  assign more_after  = !phase_r && last_r && close_emits;
  assign slot_free   = !out_valid_r || out_ready;

  assign pos_new = m1_r - u_res[SW-1:0];

  // point fed to the side-value multiplies; cached side values of the
  // previous and first vertex are redone after a line write
  always_comb begin
    case (pt_r)
      pec_pkg::PT_PREV: begin
        px = prev_x_r;
        py = prev_y_r;
      end
      pec_pkg::PT_FIRST: begin
        px = first_x_r;
        py = first_y_r;
      end
      default: begin
        px = cur_x_r;
        py = cur_y_r;
      end
    endcase
  end

  // unit operands
  always_comb begin
    u_ctl.req = 1'b0;
    u_ctl.op  = pec_pkg::OP_MUL;
    a_in      = '0;
    u_opb     = '0;
    case (state_r)
      pec_pkg::ST_POS1: begin
        // (ex - sx) * (Py - sy)
        u_ctl.req = 1'b1;
        a_in      = {py[W-1], py} - {sy_r[W-1], sy_r};
        u_opb     = {{(BW-AW){ldx[AW-1]}}, ldx};
      end
      pec_pkg::ST_POS2: begin
        // (ey - sy) * (Px - sx)
        u_ctl.req = 1'b1;
        a_in      = {px[W-1], px} - {sx_r[W-1], sx_r};
        u_opb     = {{(BW-AW){ldy[AW-1]}}, ldy};
      end
      pec_pkg::ST_MUL_A: begin
        // I * D
        u_ctl.req = 1'b1;
        a_in      = {i_c[W-1], i_c};
        u_opb     = d_r;
      end
      pec_pkg::ST_MUL_B: begin
        // (K - I) * pos(I)
        u_ctl.req = 1'b1;
        a_in      = {k_c[W-1], k_c} - {i_c[W-1], i_c};
        u_opb     = {{(BW-SW){ip[SW-1]}}, ip};
      end
      pec_pkg::ST_DIV: begin
        u_ctl.req = 1'b1;
        u_ctl.op  = pec_pkg::OP_DIV;
        u_opb     = d_r;
      end
      default: ;
    endcase
  end

  assign u_opa = (state_r == pec_pkg::ST_DIV) ? t_r : {{(PW-AW){a_in[AW-1]}}, a_in};

  pec_unit #(
    .W (W)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .opa   (u_opa),
    .opb   (u_opb),
    .rsp   (u_rsp),
    .res   (u_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pec_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pec_pkg::ST_POS1;
        end
      end
      pec_pkg::ST_POS1: begin
        if (u_rsp.done) begin
          state_nxt = pec_pkg::ST_POS2;
        end
      end
      pec_pkg::ST_POS2: begin
        if (u_rsp.done) begin
          state_nxt = (pt_r == pec_pkg::PT_CUR) ? pec_pkg::ST_EDGE : pec_pkg::ST_POS1;
        end
      end
      pec_pkg::ST_EDGE: begin
        if (!edge_on) begin
          state_nxt = pec_pkg::ST_NEXT;
        end else if (iin != kin) begin
          state_nxt = pec_pkg::ST_DIFF;
        end else if (kin) begin
          state_nxt = pec_pkg::ST_EMIT_K;
        end else begin
          state_nxt = pec_pkg::ST_NEXT;
        end
      end
      pec_pkg::ST_DIFF: state_nxt = pec_pkg::ST_MUL_A;
      pec_pkg::ST_MUL_A: begin
        if (u_rsp.done) begin
          state_nxt = pec_pkg::ST_MUL_B;
        end
      end
      pec_pkg::ST_MUL_B: begin
        if (u_rsp.done) begin
          state_nxt = pec_pkg::ST_DIV;
        end
      end
      pec_pkg::ST_DIV: begin
        if (u_rsp.done) begin
          state_nxt = axis_r ? pec_pkg::ST_EMIT_X : pec_pkg::ST_MUL_A;
        end
      end
      pec_pkg::ST_EMIT_X: begin
        if (slot_free) begin
          state_nxt = kin ? pec_pkg::ST_EMIT_K : pec_pkg::ST_NEXT;
        end
      end
      pec_pkg::ST_EMIT_K: begin
        if (slot_free) begin
          state_nxt = pec_pkg::ST_NEXT;
        end
      end
      pec_pkg::ST_NEXT: begin
        if (!phase_r) begin
          state_nxt = pec_pkg::ST_EDGE;
        end else if (last_r && !emitted_r) begin
          state_nxt = pec_pkg::ST_EMPTY;
        end else begin
          state_nxt = pec_pkg::ST_IDLE;
        end
      end
      pec_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_nxt = pec_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pec_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    first_x_nxt     = first_x_r;
    first_y_nxt     = first_y_r;
    prev_x_nxt      = prev_x_r;
    prev_y_nxt      = prev_y_r;
    pos_cur_nxt     = pos_cur_r;
    pos_prev_nxt    = pos_prev_r;
    pos_first_nxt   = pos_first_r;
    m1_nxt          = m1_r;
    d_nxt           = d_r;
    t_nxt           = t_r;
    cx_nxt          = cx_r;
    cy_nxt          = cy_r;
    last_nxt        = last_r;
    mid_nxt         = mid_r;
    phase_nxt       = phase_r;
    axis_nxt        = axis_r;
    emitted_nxt     = emitted_r;
    pt_nxt          = pt_r;
    dirty_nxt       = dirty_r;
    out_x_nxt       = out_x_r;
    out_y_nxt       = out_y_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    case (state_r)
      pec_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_x_nxt   = in_vertex_x;
          cur_y_nxt   = in_vertex_y;
          last_nxt    = in_end_of_polygon;
          emitted_nxt = 1'b0;
          phase_nxt   = 1'b0;
          pt_nxt      = (mid_r && dirty_r) ? pec_pkg::PT_PREV : pec_pkg::PT_CUR;
        end
      end
      pec_pkg::ST_POS1: begin
        if (u_rsp.done) begin
          m1_nxt = u_res[SW-1:0];
        end
      end
      pec_pkg::ST_POS2: begin
        if (u_rsp.done) begin
          case (pt_r)
            pec_pkg::PT_PREV: begin
              pos_prev_nxt = pos_new;
              pt_nxt       = pec_pkg::PT_FIRST;
            end
            pec_pkg::PT_FIRST: begin
              pos_first_nxt = pos_new;
              pt_nxt        = pec_pkg::PT_CUR;
            end
            default: begin
              pos_cur_nxt = pos_new;
              dirty_nxt   = 1'b0;
              if (!mid_r) begin
                first_x_nxt   = cur_x_r;
                first_y_nxt   = cur_y_r;
                pos_first_nxt = pos_new;
              end
            end
          endcase
        end
      end
      pec_pkg::ST_EDGE: begin
        axis_nxt = 1'b0;
      end
      pec_pkg::ST_DIFF: begin
        d_nxt = {ip[SW-1], ip} - {kp[SW-1], kp};
      end
      pec_pkg::ST_MUL_A: begin
        if (u_rsp.done) begin
          t_nxt = u_res;
        end
      end
      pec_pkg::ST_MUL_B: begin
        if (u_rsp.done) begin
          t_nxt = t_r + u_res;
        end
      end
      pec_pkg::ST_DIV: begin
        if (u_rsp.done) begin
          if (axis_r) begin
            cy_nxt = u_res[W-1:0];
          end else begin
            cx_nxt   = u_res[W-1:0];
            axis_nxt = 1'b1;
          end
        end
      end
      pec_pkg::ST_EMIT_X: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_x_nxt       = cx_r;
          out_y_nxt       = cy_r;
          out_present_nxt = 1'b1;
          out_last_nxt    = last_r && !kin && !more_after;
          emitted_nxt     = 1'b1;
        end
      end
      pec_pkg::ST_EMIT_K: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_x_nxt       = kx;
          out_y_nxt       = ky;
          out_present_nxt = 1'b1;
          out_last_nxt    = last_r && !more_after;
          emitted_nxt     = 1'b1;
        end
      end
      pec_pkg::ST_NEXT: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          prev_x_nxt   = cur_x_r;
          prev_y_nxt   = cur_y_r;
          pos_prev_nxt = pos_cur_r;
          mid_nxt      = !last_r;
        end
      end
      pec_pkg::ST_EMPTY: begin
        // final vertex emitted nothing: one empty beat closes the polygon
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_x_nxt       = '0;
          out_y_nxt       = '0;
          out_present_nxt = 1'b0;
          out_last_nxt    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pec_pkg::ST_IDLE;
      mid_r       <= 1'b0;
      last_r      <= 1'b0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mid_r       <= mid_nxt;
      last_r      <= last_nxt;
      dirty_r     <= dirty_nxt | cfg_wr_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r       <= cur_x_nxt;
    cur_y_r       <= cur_y_nxt;
    first_x_r     <= first_x_nxt;
    first_y_r     <= first_y_nxt;
    prev_x_r      <= prev_x_nxt;
    prev_y_r      <= prev_y_nxt;
    pos_cur_r     <= pos_cur_nxt;
    pos_prev_r    <= pos_prev_nxt;
    pos_first_r   <= pos_first_nxt;
    m1_r          <= m1_nxt;
    d_r           <= d_nxt;
    t_r           <= t_nxt;
    cx_r          <= cx_nxt;
    cy_r          <= cy_nxt;
    phase_r       <= phase_nxt;
    axis_r        <= axis_nxt;
    emitted_r     <= emitted_nxt;
    pt_r          <= pt_nxt;
    out_x_r       <= out_x_nxt;
    out_y_r       <= out_y_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_ready    = (state_r == pec_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_present = out_present_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  // between vertices the shared unit must be quiet
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !u_rsp.busy)
    else $error("arithmetic unit busy while taking a vertex");

  // unit only finishes work that the sequencer is still waiting on
  a_done_req: assert property (@(posedge clk) disable iff (!rst_n)
    u_rsp.done |-> u_ctl.req)
    else $error("unit result with no pending request");

  // after a final vertex the polygon tracking is back at its start
  a_poly_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && last_r) |-> !mid_r)
    else $error("polygon still open after its last vertex");

  // an empty beat is only the zeroed terminator
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> (out_last_r && out_x_r == '0 && out_y_r == '0))
    else $error("empty beat that is not the terminator");
`endif

endmodule

`default_nettype wire

// ----- test/tb_polygon_edge_clip.sv -----
`timescale 1ns / 1ps

module tb_polygon_edge_clip;

  localparam int COORD_W = 32;
  // quiet time before a line write and at the end: enough for one vertex with
  // two crossing edges
  localparam int SETTLE = 600;
  localparam int PHASE_ITEMS = 62;

  typedef logic signed [COORD_W-1:0] coord_t;
  // wide enough for exact crossing numerators (about 100 bits at 32-bit coords)
  typedef logic signed [127:0] wide_t;

  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t ONE = 32'sh0001_0000;  // 1.0 in Q16.16

  typedef struct {
    coord_t x;
    coord_t y;
    logic present;
    logic last;
  } clip_vertex_t;

  // Clipping predictor plus the queue of clipped vertices still owed by the block.
  class clip_scoreboard;
    coord_t line_sx, line_sy, line_ex, line_ey;
    coord_t first_x, first_y, prev_x, prev_y;
    bit mid_polygon;
    clip_vertex_t batch[$];
    clip_vertex_t owed[$];
    int errors;

    function new();
      line_sx = '0;
      line_sy = '0;
      line_ex = '0;
      line_ey = '0;
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      mid_polygon = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [pec_pkg::CFG_INDEX_W-1:0] idx, coord_t value);
      case (idx)
        pec_pkg::REG_LINE_START_X: line_sx = value;
        pec_pkg::REG_LINE_START_Y: line_sy = value;
        pec_pkg::REG_LINE_END_X:   line_ex = value;
        pec_pkg::REG_LINE_END_Y:   line_ey = value;
        default: ;
      endcase
    endfunction

    function wide_t widen(coord_t v);
      return v;
    endfunction

    // cross product of the line with the point; negative means inside
    function wide_t side_of(coord_t px, coord_t py);
      return (widen(line_ex) - widen(line_sx)) * (widen(py) - widen(line_sy))
           - (widen(line_ey) - widen(line_sy)) * (widen(px) - widen(line_sx));
    endfunction

    // one coordinate of the crossing point, truncated toward zero and saturated
    function coord_t crossing(coord_t i, coord_t k, wide_t i_side, wide_t denom);
      wide_t q;
      if (denom == 0) return '0;
      q = (widen(i) * denom + (widen(k) - widen(i)) * i_side) / denom;
      if (q > widen(COORD_MAX)) return COORD_MAX;
      if (q < widen(COORD_MIN)) return COORD_MIN;
      return q[COORD_W-1:0];
    endfunction

    function void emit(coord_t x, coord_t y, logic present);
      clip_vertex_t v;
      v.x = x;
      v.y = y;
      v.present = present;
      v.last = 1'b0;
      batch = {batch, v};
    endfunction

    function void clip_edge(coord_t ix, coord_t iy, coord_t kx, coord_t ky);
      wide_t i_side, k_side, denom;
      bit i_in, k_in;
      i_side = side_of(ix, iy);
      k_side = side_of(kx, ky);
      i_in = i_side < 0;
      k_in = k_side < 0;
      if (i_in != k_in) begin
        denom = i_side - k_side;
        emit(crossing(ix, kx, i_side, denom), crossing(iy, ky, i_side, denom), 1'b1);
      end
      if (k_in) emit(kx, ky, 1'b1);
    endfunction

    function void note_vertex(coord_t x, coord_t y, logic eop);
      batch.delete();
      if (!mid_polygon) begin
        first_x = x;
        first_y = y;
      end else begin
        clip_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      mid_polygon = 1'b1;
      if (eop) begin
        // closing edge; a lone vertex closes onto itself
        clip_edge(x, y, first_x, first_y);
        if (batch.size() == 0) emit('0, '0, 1'b0);
        batch[batch.size()-1].last = 1'b1;
        mid_polygon = 1'b0;
      end
      foreach (batch[i]) owed = {owed, batch[i]};
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(coord_t x, coord_t y, logic present, logic last);
      clip_vertex_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat x=%h y=%h present=%b last=%b",
                         x, y, present, last));
        return;
      end
      want = owed.pop_front();
      if (x !== want.x) report($sformatf("out_x %h, want %h", x, want.x));
      if (y !== want.y) report($sformatf("out_y %h, want %h", y, want.y));
      if (present !== want.present)
        report($sformatf("out_present %b, want %b", present, want.present));
      if (last !== want.last) report($sformatf("out_last %b, want %b", last, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_vertex_x = '0;
  coord_t in_vertex_y = '0;
  logic in_end_of_polygon = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_x, out_y;
  logic out_present, out_last;
  logic cfg_wr_en = 1'b0;
  logic [pec_pkg::CFG_INDEX_W-1:0] cfg_index = pec_pkg::REG_LINE_START_X;
  logic [COORD_W-1:0] cfg_wdata = '0;

  polygon_edge_clip #(.COORD_WIDTH(COORD_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y),
    .in_end_of_polygon(in_end_of_polygon),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x(out_x),
    .out_y(out_y),
    .out_present(out_present),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  clip_scoreboard sb = new();

  // receiver hold-off request, in cycles; the receiver process counts it down
  int rx_hold = 0;
  int items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop. Worst case per vertex is the work of two crossing edges, four results
  // each behind the longest receiver stall, plus the longest sender gap; the limit
  // allows five times that over every vertex sent.
  initial begin
    #30_000_000;
    $display("polygon_edge_clip regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Gap and coordinate helpers
  // ---------------------------------------------------------------------------

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return -1;
      3: return 1;
      default: return '0;
    endcase
  endfunction

  // 0: full range, 1: a few units around the origin, 2: extremes, else a mix
  function automatic coord_t rand_coord(int mode);
    int m;
    m = (mode > 2) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
      default: return pick_extreme();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; all called right after a rising edge
  // ---------------------------------------------------------------------------

  // valid stays up after the beat unless a gap follows; callers lower it
  // through drain() before doing anything else
  task automatic send_vertex(coord_t x, coord_t y, logic eop, int gap);
    in_valid <= 1'b1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_end_of_polygon <= eop;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(x, y, eop);
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every owed clipped vertex
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // block must be idle before the line moves: a vertex with no output may
  // still be in the multiplier after the last owed beat
  task automatic settle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [pec_pkg::CFG_INDEX_W-1:0] idx, coord_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic write_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    write_reg(pec_pkg::REG_LINE_START_X, sx);
    write_reg(pec_pkg::REG_LINE_START_Y, sy);
    write_reg(pec_pkg::REG_LINE_END_X, ex);
    write_reg(pec_pkg::REG_LINE_END_Y, ey);
    cfg_wr_en <= 1'b0;
  endtask

  // 0: anywhere, 1: short line near origin, 2: axis aligned,
  // 3: zero length (nothing is inside), 4: corners of the coordinate range
  task automatic random_line(int mode);
    coord_t sx, sy, ex, ey;
    case (mode)
      0: begin
        sx = rand_coord(0); sy = rand_coord(0);
        ex = rand_coord(0); ey = rand_coord(0);
      end
      1: begin
        sx = rand_coord(1); sy = rand_coord(1);
        ex = rand_coord(1); ey = rand_coord(1);
      end
      2: begin
        sx = rand_coord(1); sy = rand_coord(1);
        ex = rand_coord(1); ey = rand_coord(1);
        if ($urandom_range(0, 1)) ey = sy;
        else ex = sx;
      end
      3: begin
        sx = rand_coord(0); sy = rand_coord(0);
        ex = sx; ey = sy;
      end
      default: begin
        sx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        sy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        ex = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        ey = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end
    endcase
    write_line(sx, sy, ex, ey);
  endtask

  // well-formed polygon, 1..8 vertices; lone and two-vertex ones now and then
  task automatic send_random_polygon(bit burst);
    int n, r, cmode;
    r = $urandom_range(0, 9);
    n = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 8);
    r = $urandom_range(0, 9);
    cmode = (r < 4) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(cmode), rand_coord(cmode), i == n - 1,
                  burst ? 0 : next_gap());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each beat, then picks next cycle's ready.
  // Random short stalls, rare long ones, occasional long always-ready stretches,
  // and the hold-off requested by the stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left, steady_left, r;
    stall_left = 0;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_x, out_y, out_present, out_last);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        out_ready <= 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          steady_left = 300;
          out_ready <= 1'b1;
        end else if (r < 40) begin
          stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                    : $urandom_range(20, 80);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int phase_start, mode;
    bit burst;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Line registers come out of reset as all zero: a zero-length line, so
    // every polygon reduces to the empty last beat.
    send_vertex(ONE, -ONE, 1'b0, 0);
    send_vertex(-5, -5, 1'b0, 2);
    send_vertex(7, -9, 1'b1, 0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1, 0);
    settle();

    // Line along +x: inside is y < 0.
    write_line('0, '0, ONE, '0);
    send_vertex(5, -7, 1'b1, 1);               // lone vertex inside
    send_vertex(3, 4, 1'b1, 0);                // lone vertex outside
    send_vertex(-ONE, -ONE, 1'b0, 0);          // square straddling the line
    send_vertex(ONE, -ONE, 1'b0, 3);
    send_vertex(ONE, ONE, 1'b0, 0);
    send_vertex(-ONE, ONE, 1'b1, 0);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0); // extreme coordinates
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1, 1);
    send_vertex(COORD_MAX, -1, 1'b0, 0);        // two-vertex polygon
    send_vertex(COORD_MIN, 1, 1'b1, 0);
    send_vertex(2, 9, 1'b0, 0);                 // fully outside, several edges
    send_vertex(COORD_MAX, 1, 1'b0, 0);
    send_vertex(-4, COORD_MAX, 1'b1, 0);
    settle();

    // Line moved between vertices of one polygon: earlier vertices are judged
    // against the new line from then on.
    send_vertex(-ONE, -ONE, 1'b0, 0);
    send_vertex(ONE, ONE, 1'b0, 0);
    settle();
    write_line('0, '0, '0, ONE);
    send_vertex(ONE, -ONE, 1'b1, 0);
    settle();

    // Diagonal spanning the whole range, square at the corners.
    write_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0, 0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1, 0);
    settle();

    // Random phases, one line setting each; the first five cover every kind.
    for (int p = 0; p < 8; p++) begin
      mode = (p < 5) ? p : $urandom_range(0, 4);
      random_line(mode);
      phase_start = items_sent;
      // long receiver hold-off while the sender keeps pushing: backs up the
      // output register and the sequencer until in_ready drops
      if (p == 1) rx_hold = 2500;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        burst = (rx_hold > 0) || ($urandom_range(0, 3) == 0);
        send_random_polygon(burst);
        if ($urandom_range(0, 19) == 0) drain();
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("polygon_edge_clip regression: pass");
    end else begin
      $display("polygon_edge_clip regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pec_pkg.sv
rtl/pec_unit.sv
rtl/polygon_edge_clip.sv
test/tb_polygon_edge_clip.sv
